// ===== sv/oba_pkg.sv =====
package oba_pkg;

    localparam int DEF_MAX_TEMP_BINS = 64;
    localparam int DEF_MAX_LON_BINS  = 256;

    localparam int SUM_W   = 36;
    localparam int CNT_W   = 20;
    localparam int VAL_W   = 15;
    localparam int CFG_W   = 15;
    localparam int CIDX_W  = 3;
    localparam int ONE_UNIT = 64;
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [CIDX_W-1:0] REG_TEMP_FIRST = 3'd0;
    localparam logic [CIDX_W-1:0] REG_TEMP_STEP  = 3'd1;
    localparam logic [CIDX_W-1:0] REG_TEMP_USED  = 3'd2;
    localparam logic [CIDX_W-1:0] REG_LON_FIRST  = 3'd3;
    localparam logic [CIDX_W-1:0] REG_LON_STEP   = 3'd4;
    localparam logic [CIDX_W-1:0] REG_LON_USED   = 3'd5;

    localparam logic [14:0] RST_TEMP_FIRST = 15'd17280;
    localparam logic [9:0]  RST_TEMP_STEP  = 10'd64;
    localparam logic [6:0]  RST_TEMP_USED  = 7'd41;
    localparam logic [14:0] RST_LON_FIRST  = 15'd3776;
    localparam logic [10:0] RST_LON_STEP   = 11'd64;
    localparam logic [8:0]  RST_LON_USED   = 9'd164;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } bin_entry_t;

endpackage

// ===== sv/overlapping_2d_binned_mean_unit.sv =====
// Binned mean table held in one synchronous memory of sum/count entries. A request is
// taken when start is high and busy is low. A read request answers with a one-cycle done
// strobe that the receiver cannot hold off; the other commands answer nothing. After reset
// and after a clear request the table is swept to zero, one entry a cycle, over all
// MAX_TEMP_BINS*MAX_LON_BINS entries (16384 by default) with busy high. An add request scans
// max(MAX_TEMP_BINS, MAX_LON_BINS) bin indices (256 by default) to find the run of bins whose
// windows hold the point. It then does a read-modify-write of the memory for each touched
// bin, through ST_RMW_RD, ST_RD_ADDR, ST_RD_DATA and ST_RMW_WR. A read outside the bins
// in use answers on the cycle after it is taken and never raises busy. Any other read keeps
// busy high through ST_RD_ADDR and ST_RD_DATA, and also through ST_DIV when the bin holds
// data and the 36-step divider runs. In both cases done is high in the cycle busy falls.
module overlapping_2d_binned_mean_unit
    import oba_pkg::*;
#(
    parameter int MAX_TEMP_BINS = DEF_MAX_TEMP_BINS,
    parameter int MAX_LON_BINS  = DEF_MAX_LON_BINS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    input  logic              cfg_we,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic [1:0]        cmd,
    input  logic [14:0]       lon,
    input  logic [14:0]       ref_temp,
    input  logic [14:0]       sample_temp,
    input  logic [5:0]        temp_bin,
    input  logic [7:0]        lon_bin,
    output logic [14:0]       mean_temp,
    output logic              has_data,
    output logic [19:0]       point_count
);

    localparam int DEPTH = MAX_TEMP_BINS * MAX_LON_BINS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MAXB  = (MAX_TEMP_BINS > MAX_LON_BINS) ? MAX_TEMP_BINS : MAX_LON_BINS;
    localparam int SW    = $clog2(MAXB + 1);
    localparam int CW    = SW + 13;
    localparam int DCW   = $clog2(SUM_W + 1);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_CLEAR   = 3'd1;
    localparam logic [2:0] ST_SCAN    = 3'd2;
    localparam logic [2:0] ST_RMW_RD  = 3'd3;
    localparam logic [2:0] ST_RMW_WR  = 3'd4;
    localparam logic [2:0] ST_RD_ADDR = 3'd5;
    localparam logic [2:0] ST_RD_DATA = 3'd6;
    localparam logic [2:0] ST_DIV     = 3'd7;

    logic [14:0] temp_first_reg;
    logic [9:0]  temp_step_reg;
    logic [6:0]  temp_used_reg;
    logic [14:0] lon_first_reg;
    logic [10:0] lon_step_reg;
    logic [8:0]  lon_used_reg;

    logic [2:0]    state_reg;
    logic [AW-1:0] addr_reg;
    logic [SW-1:0] scan_reg;
    logic [CW-1:0] ct_reg, cl_reg;
    logic          kfound_reg, lfound_reg;
    logic [SW-1:0] khi_reg, llo_reg, lhi_reg, kcur_reg, lcur_reg;
    logic [14:0]   lon_reg, ref_reg, sample_reg;

    logic [SUM_W-1:0] quot_reg;
    logic [CNT_W-1:0] rem_reg, divisor_reg;
    logic [DCW-1:0]   dcnt_reg;

    logic        done_reg, has_reg;
    logic [14:0] mean_reg;
    logic [19:0] cnt_out_reg;

    bin_entry_t mem [DEPTH];
    bin_entry_t rdata_reg;
    bin_entry_t wdata;
    logic       mem_we;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr_reg] <= wdata;
        end
        rdata_reg <= mem[addr_reg];
    end

    always_comb
    begin
        mem_we = 1'b0;
        wdata  = '0;
        if (state_reg == ST_CLEAR)
        begin
            mem_we = 1'b1;
        end
        else if (state_reg == ST_RMW_WR)
        begin
            wdata = rdata_reg;
            if (rdata_reg.count < COUNT_MAX)
            begin
                mem_we      = 1'b1;
                wdata.count = rdata_reg.count + CNT_W'(1);
                wdata.sum   = rdata_reg.sum + SUM_W'(sample_reg);
            end
        end
    end

    // Window tests for the scan index against both running bin centers.
    logic match_t, match_l, scan_last;
    always_comb
    begin
        match_t = (16'(scan_reg) < 16'(MAX_TEMP_BINS)) && (16'(scan_reg) < 16'(temp_used_reg))
                  && (CW'(ref_reg) + CW'(temp_step_reg) >= ct_reg)
                  && (CW'(ref_reg) <= ct_reg + CW'(temp_step_reg) + CW'(ONE_UNIT));
        match_l = (16'(scan_reg) < 16'(MAX_LON_BINS)) && (16'(scan_reg) < 16'(lon_used_reg))
                  && (CW'(lon_reg) + CW'(lon_step_reg) >= cl_reg)
                  && (CW'(lon_reg) <= cl_reg + CW'(lon_step_reg) + CW'(ONE_UNIT));
        scan_last = (32'(scan_reg) == MAXB - 1);
    end

    logic read_ok;
    assign read_ok = (16'(temp_bin) < 16'(MAX_TEMP_BINS)) && (16'(temp_bin) < 16'(temp_used_reg))
                     && (16'(lon_bin) < 16'(MAX_LON_BINS)) && (16'(lon_bin) < 16'(lon_used_reg));

    logic [CNT_W:0] trial;
    assign trial = {rem_reg, quot_reg[SUM_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_first_reg <= RST_TEMP_FIRST;
            temp_step_reg  <= RST_TEMP_STEP;
            temp_used_reg  <= RST_TEMP_USED;
            lon_first_reg  <= RST_LON_FIRST;
            lon_step_reg   <= RST_LON_STEP;
            lon_used_reg   <= RST_LON_USED;
            state_reg      <= ST_CLEAR;
            addr_reg       <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TEMP_FIRST: temp_first_reg <= cfg_data[14:0];
                    REG_TEMP_STEP:  temp_step_reg  <= cfg_data[9:0];
                    REG_TEMP_USED:  temp_used_reg  <= cfg_data[6:0];
                    REG_LON_FIRST:  lon_first_reg  <= cfg_data[14:0];
                    REG_LON_STEP:   lon_step_reg   <= cfg_data[10:0];
                    REG_LON_USED:   lon_used_reg   <= cfg_data[8:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        unique case (cmd)
                            CMD_ADD:
                            begin
                                lon_reg    <= lon;
                                ref_reg    <= ref_temp;
                                sample_reg <= sample_temp;
                                scan_reg   <= '0;
                                ct_reg     <= CW'(temp_first_reg);
                                cl_reg     <= CW'(lon_first_reg);
                                kfound_reg <= 1'b0;
                                lfound_reg <= 1'b0;
                                state_reg  <= ST_SCAN;
                            end
                            CMD_READ:
                            begin
                                if (read_ok)
                                begin
                                    addr_reg  <= AW'(AW'(temp_bin) * AW'(MAX_LON_BINS)
                                                     + AW'(lon_bin));
                                    state_reg <= ST_RD_ADDR;
                                end
                                else
                                begin
                                    mean_reg    <= '0;
                                    has_reg     <= 1'b0;
                                    cnt_out_reg <= '0;
                                    done_reg    <= 1'b1;
                                end
                            end
                            CMD_CLEAR:
                            begin
                                addr_reg  <= '0;
                                state_reg <= ST_CLEAR;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_CLEAR:
                begin
                    if (32'(addr_reg) == DEPTH - 1)
                    begin
                        addr_reg  <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        addr_reg <= addr_reg + AW'(1);
                    end
                end
                ST_SCAN:
                begin
                    // Matching bins form a contiguous run along each axis.
                    if (match_t)
                    begin
                        khi_reg <= scan_reg;
                        if (!kfound_reg)
                        begin
                            kcur_reg <= scan_reg;
                        end
                        kfound_reg <= 1'b1;
                    end
                    if (match_l)
                    begin
                        lhi_reg <= scan_reg;
                        if (!lfound_reg)
                        begin
                            llo_reg  <= scan_reg;
                            lcur_reg <= scan_reg;
                        end
                        lfound_reg <= 1'b1;
                    end
                    ct_reg   <= ct_reg + CW'(temp_step_reg);
                    cl_reg   <= cl_reg + CW'(lon_step_reg);
                    scan_reg <= scan_reg + SW'(1);
                    if (scan_last)
                    begin
                        if ((kfound_reg || match_t) && (lfound_reg || match_l))
                        begin
                            state_reg <= ST_RMW_RD;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_RMW_RD:
                begin
                    addr_reg  <= AW'(AW'(kcur_reg) * AW'(MAX_LON_BINS) + AW'(lcur_reg));
                    state_reg <= ST_RD_ADDR;
                end
                ST_RD_ADDR:
                begin
                    state_reg <= ST_RD_DATA;
                end
                ST_RD_DATA:
                begin
                    // Data for addr_reg is now registered; either update or answer a read.
                    if (kfound_reg)
                    begin
                        state_reg <= ST_RMW_WR;
                    end
                    else if (rdata_reg.count == '0)
                    begin
                        mean_reg    <= '0;
                        has_reg     <= 1'b0;
                        cnt_out_reg <= '0;
                        done_reg    <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                    else
                    begin
                        quot_reg    <= rdata_reg.sum;
                        divisor_reg <= rdata_reg.count;
                        rem_reg     <= '0;
                        dcnt_reg    <= '0;
                        cnt_out_reg <= rdata_reg.count;
                        state_reg   <= ST_DIV;
                    end
                end
                ST_RMW_WR:
                begin
                    if (lcur_reg == lhi_reg)
                    begin
                        lcur_reg <= llo_reg;
                        if (kcur_reg == khi_reg)
                        begin
                            kfound_reg <= 1'b0;
                            state_reg  <= ST_IDLE;
                        end
                        else
                        begin
                            kcur_reg  <= kcur_reg + SW'(1);
                            state_reg <= ST_RMW_RD;
                        end
                    end
                    else
                    begin
                        lcur_reg  <= lcur_reg + SW'(1);
                        state_reg <= ST_RMW_RD;
                    end
                end
                ST_DIV:
                begin
                    if (trial >= {1'b0, divisor_reg})
                    begin
                        rem_reg  <= CNT_W'(trial - {1'b0, divisor_reg});
                        quot_reg <= {quot_reg[SUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= trial[CNT_W-1:0];
                        quot_reg <= {quot_reg[SUM_W-2:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg + DCW'(1);
                    if (32'(dcnt_reg) == SUM_W - 1)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (state_reg == ST_DIV && 32'(dcnt_reg) == SUM_W - 1)
            begin
                mean_reg <= (trial >= {1'b0, divisor_reg}) ? {quot_reg[13:0], 1'b1}
                                                          : {quot_reg[13:0], 1'b0};
                has_reg  <= 1'b1;
                done_reg <= 1'b1;
            end
            if (state_reg == ST_IDLE && start && cmd == CMD_READ)
            begin
                kfound_reg <= 1'b0;
            end
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign mean_temp   = mean_reg;
    assign has_data    = has_reg;
    assign point_count = cnt_out_reg;

endmodule
